FILE: rtl/tsr_pkg.sv
// shared constants and controller/datapath interface types for the stream reassembly block
package tsr_pkg;

  localparam int BUF_BYTES = 16384;
  localparam int OFF_W     = 14;
  localparam int LEN_W     = 15;
  localparam int MAX_HOLES = 128;
  localparam int HIDX_W    = 7;
  localparam int HCNT_W    = 8;
  localparam int HENT_W    = 2 * LEN_W;

  localparam logic [1:0] REQ_SEG   = 2'd0;
  localparam logic [1:0] REQ_READ  = 2'd1;
  localparam logic [1:0] REQ_CLEAR = 2'd2;

  typedef struct packed {
    logic latch;
    logic dec;
    logic clr_start;
    logic clr_step;
    logic byte_upd;
    logic rd_done;
    logic emit_plain;
    logic wset;
    logic wrd;
    logic wproc;
    logic wspl;
    logic wfin;
  } cmd_t;

  typedef struct packed {
    logic dec_clear;
    logic dec_read;
    logic dec_byte;
    logic dec_walk;
    logic last;
    logic clr_last;
    logic hcnt_zero;
    logic split;
    logic wdone;
  } status_t;

endpackage

FILE: rtl/tsr_ctrl.sv
// sequencing state machine for the stream reassembly block
module tsr_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  tsr_pkg::status_t  st,
  output tsr_pkg::cmd_t     cmd
);

  localparam logic [3:0] S_CLR   = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_DEC   = 4'd2;
  localparam logic [3:0] S_BYTE  = 4'd3;
  localparam logic [3:0] S_RDRES = 4'd4;
  localparam logic [3:0] S_WSET  = 4'd5;
  localparam logic [3:0] S_WRD   = 4'd6;
  localparam logic [3:0] S_WPROC = 4'd7;
  localparam logic [3:0] S_WSPL  = 4'd8;
  localparam logic [3:0] S_WFIN  = 4'd9;

  logic [3:0] state_r;
  logic [3:0] state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_CLR: begin
        cmd.clr_step = 1'b1;
        if (st.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd.latch = 1'b1;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        cmd.dec = 1'b1;
        priority if (st.dec_clear) begin
          cmd.clr_start = 1'b1;
          state_nxt     = S_CLR;
        end else if (st.dec_read) begin
          state_nxt = S_RDRES;
        end else if (st.dec_byte) begin
          state_nxt = S_BYTE;
        end else if (st.dec_walk) begin
          state_nxt = S_WSET;
        end else begin
          cmd.emit_plain = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      S_BYTE: begin
        cmd.byte_upd = 1'b1;
        if (st.last) begin
          state_nxt = S_WSET;
        end else begin
          cmd.emit_plain = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      S_RDRES: begin
        cmd.rd_done = 1'b1;
        state_nxt   = S_IDLE;
      end
      S_WSET: begin
        cmd.wset  = 1'b1;
        state_nxt = st.hcnt_zero ? S_WFIN : S_WRD;
      end
      S_WRD: begin
        cmd.wrd   = 1'b1;
        state_nxt = S_WPROC;
      end
      S_WPROC: begin
        cmd.wproc = 1'b1;
        priority if (st.split) state_nxt = S_WSPL;
        else if (st.wdone)     state_nxt = S_WFIN;
        else                   state_nxt = S_WRD;
      end
      S_WSPL: begin
        cmd.wspl  = 1'b1;
        state_nxt = st.wdone ? S_WFIN : S_WRD;
      end
      S_WFIN: begin
        cmd.wfin  = 1'b1;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_CLR;
      end
    endcase
  end

endmodule

FILE: rtl/tsr_dp.sv
// datapath: byte buffer, written map, hole list banks, counters and result registers
module tsr_dp (
  input  logic                       clk,
  input  logic                       rst_n,
  input  tsr_pkg::cmd_t              cmd,
  output tsr_pkg::status_t           st,
  input  logic                       policy,
  input  logic [1:0]                 in_req_type,
  input  logic [31:0]                in_seg_seq,
  input  logic [7:0]                 in_data_byte,
  input  logic                       in_first_byte,
  input  logic                       in_last_byte,
  input  logic                       in_no_payload,
  input  logic [tsr_pkg::OFF_W-1:0]  in_read_offset,
  output logic                       out_valid,
  output logic                       out_delivery_valid,
  output logic [tsr_pkg::OFF_W-1:0]  out_delivery_start,
  output logic [tsr_pkg::LEN_W-1:0]  out_delivery_len,
  output logic                       out_first_delivery,
  output logic [31:0]                out_out_of_order_count,
  output logic [31:0]                out_repeat_count,
  output logic [31:0]                out_conflict_count,
  output logic                       out_conflict_seen,
  output logic [7:0]                 out_read_data,
  output logic                       out_read_written
);

  localparam int OW = tsr_pkg::OFF_W;
  localparam int LW = tsr_pkg::LEN_W;
  localparam int HW = tsr_pkg::HIDX_W;
  localparam int CW = tsr_pkg::HCNT_W;
  localparam logic [LW-1:0] BUF_L = LW'(tsr_pkg::BUF_BYTES);

  // latched request
  logic [1:0]    req_r;
  logic [31:0]   seq_r;
  logic [7:0]    data_r;
  logic          first_r, last_r, empty_r;
  logic [OW-1:0] roff_r;

  // flow state
  logic [31:0]   base_r;
  logic          base_known_r;
  logic [LW-1:0] highest_r, deliv_r;
  logic [OW-1:0] off_r;
  logic          oor_r;
  logic [LW-1:0] idx_r;
  logic [31:0]   ooo_r, rtx_r, cfl_r;
  logic [OW-1:0] pos_r;
  logic [OW-1:0] clr_idx_r;
  logic          sel_r;
  logic [CW-1:0] hcnt_r, cnt_r, i_r, j_r;
  logic [LW-1:0] hi_r, cend_r, spl_end_r;
  logic          close_en_r;

  // memories
  logic [7:0]          byte_mem [tsr_pkg::BUF_BYTES];
  logic                wmap_mem [tsr_pkg::BUF_BYTES];
  logic [tsr_pkg::HENT_W-1:0] hole_mem [2*tsr_pkg::MAX_HOLES];
  logic [7:0]          byte_q;
  logic                wmap_q;
  logic [tsr_pkg::HENT_W-1:0] hole_q;

  logic          flow_clr;
  assign flow_clr = !rst_n || cmd.clr_start;

  // decode
  logic [31:0]   base_eff, diff;
  logic          new_oor, eff_oor;
  logic [OW-1:0] new_off, eff_off, rd_addr;
  logic [LW-1:0] eff_idx, pos;
  logic          is_seg;

  always_comb begin
    base_eff = base_known_r ? base_r : seq_r;
    diff     = seq_r - base_eff;
    new_oor  = |diff[31:OW];
    new_off  = diff[OW-1:0];
    eff_oor  = first_r ? new_oor : oor_r;
    eff_off  = first_r ? new_off : off_r;
    eff_idx  = first_r ? '0 : idx_r;
    pos      = {1'b0, eff_off} + eff_idx;
    is_seg   = (req_r == tsr_pkg::REQ_SEG);
    rd_addr  = (req_r == tsr_pkg::REQ_READ) ? roff_r : pos[OW-1:0];
  end

  // walk setup
  logic [LW:0]   sum;
  logic [LW-1:0] hi_c, high_c;
  always_comb begin
    sum    = {2'b00, off_r} + {1'b0, idx_r};
    hi_c   = (sum > {1'b0, BUF_L}) ? BUF_L : sum[LW-1:0];
    high_c = (hi_c > highest_r) ? hi_c : highest_r;
  end

  // hole entry processing
  logic [LW-1:0] hs, he, lo;
  logic          c1, c2, c3, c4, room;
  logic          hole_we;
  logic [HW:0]   hole_waddr;
  logic [tsr_pkg::HENT_W-1:0] hole_wdata;
  logic [LW-1:0] wr_start;
  logic          wr_any;

  always_comb begin
    hs   = hole_q[2*LW-1:LW];
    he   = hole_q[LW-1:0];
    lo   = {1'b0, off_r};
    c1   = close_en_r && (lo <= hs) && (hi_r >= he);
    c2   = close_en_r && (lo <= hs) && (hi_r > hs);
    c3   = close_en_r && (lo < he) && (hi_r >= he);
    c4   = close_en_r && (hs < lo) && (hi_r < he);
    room = (cnt_r < CW'(tsr_pkg::MAX_HOLES));
    hole_we    = 1'b0;
    hole_waddr = {~sel_r, j_r[HW-1:0]};
    hole_wdata = {hs, he};
    if (cmd.clr_step) begin
      hole_we    = (clr_idx_r == '0);
      hole_waddr = '0;
      hole_wdata = {{LW{1'b0}}, BUF_L};
    end else if (cmd.wproc) begin
      hole_we = !c1;
      priority if (c1)    hole_wdata = {hs, he};
      else if (c2)        hole_wdata = {hi_r, he};
      else if (c3)        hole_wdata = {hs, lo};
      else if (c4 && room) hole_wdata = {hs, lo};
      else                hole_wdata = {hs, he};
    end else if (cmd.wspl) begin
      hole_we    = 1'b1;
      hole_wdata = {hi_r, spl_end_r};
    end
    wr_start = hole_wdata[2*LW-1:LW];
    wr_any   = (cmd.wproc && !c1) || cmd.wspl;
  end

  // status
  always_comb begin
    st.dec_clear = (req_r == tsr_pkg::REQ_CLEAR);
    st.dec_read  = (req_r == tsr_pkg::REQ_READ);
    st.dec_byte  = is_seg && !eff_oor && !empty_r && (pos < BUF_L);
    st.dec_walk  = is_seg && !eff_oor && last_r;
    st.last      = last_r;
    st.clr_last  = (clr_idx_r == {OW{1'b1}});
    st.hcnt_zero = (hcnt_r == '0);
    st.split     = c4 && room;
    st.wdone     = (i_r == hcnt_r);
  end

  // memory ports
  logic byte_we, wmap_we;
  logic [OW-1:0] wmap_waddr;
  assign byte_we    = cmd.byte_upd && (!wmap_q || ((byte_q != data_r) && policy));
  assign wmap_we    = cmd.clr_step || (cmd.byte_upd && !wmap_q);
  assign wmap_waddr = cmd.clr_step ? clr_idx_r : pos_r;

  always_ff @(posedge clk) begin
    if (cmd.dec) byte_q <= byte_mem[rd_addr];
    if (byte_we) byte_mem[pos_r] <= data_r;
  end

  always_ff @(posedge clk) begin
    if (cmd.dec) wmap_q <= wmap_mem[rd_addr];
    if (wmap_we) wmap_mem[wmap_waddr] <= !cmd.clr_step;
  end

  always_ff @(posedge clk) begin
    if (cmd.wrd) hole_q <= hole_mem[{sel_r, i_r[HW-1:0]}];
    if (hole_we) hole_mem[hole_waddr] <= hole_wdata;
  end

  // request latch
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      req_r   <= in_req_type;
      seq_r   <= in_seg_seq;
      data_r  <= in_data_byte;
      first_r <= in_first_byte;
      last_r  <= in_last_byte;
      empty_r <= in_no_payload;
      roff_r  <= in_read_offset;
    end
  end

  // flow state
  always_ff @(posedge clk) begin
    if (flow_clr) begin
      base_r       <= '0;
      base_known_r <= 1'b0;
      highest_r    <= '0;
      deliv_r      <= '0;
      off_r        <= '0;
      oor_r        <= 1'b0;
      idx_r        <= '0;
      ooo_r        <= '0;
      rtx_r        <= '0;
      cfl_r        <= '0;
      clr_idx_r    <= '0;
      sel_r        <= 1'b0;
      hcnt_r       <= CW'(1);
    end else begin
      if (cmd.clr_step) clr_idx_r <= clr_idx_r + OW'(1);
      if (cmd.dec) begin
        pos_r <= pos[OW-1:0];
        if (is_seg && first_r) begin
          if (!base_known_r) begin
            base_r       <= seq_r;
            base_known_r <= 1'b1;
          end
          off_r <= new_off;
          oor_r <= new_oor;
          idx_r <= '0;
          if (!new_oor && ({1'b0, new_off} < highest_r)) ooo_r <= ooo_r + 32'd1;
        end
      end
      if (cmd.byte_upd) begin
        idx_r <= idx_r + LW'(1);
        if (wmap_q) begin
          if (byte_q == data_r) rtx_r <= rtx_r + 32'd1;
          else                  cfl_r <= cfl_r + 32'd1;
        end
      end
      if (cmd.wset) begin
        hi_r       <= hi_c;
        close_en_r <= (hi_c > {1'b0, off_r});
        highest_r  <= high_c;
        cend_r     <= high_c;
        i_r        <= '0;
        j_r        <= '0;
        cnt_r      <= hcnt_r;
      end
      if (cmd.wrd) i_r <= i_r + CW'(1);
      if (cmd.wproc) begin
        spl_end_r <= he;
        if (c1)             cnt_r <= cnt_r - CW'(1);
        else if (c4 && room) cnt_r <= cnt_r + CW'(1);
      end
      if (wr_any) begin
        j_r <= j_r + CW'(1);
        if ((wr_start >= deliv_r) && (wr_start < cend_r)) cend_r <= wr_start;
      end
      if (cmd.wfin) begin
        hcnt_r <= j_r;
        sel_r  <= ~sel_r;
        if (cend_r > deliv_r) deliv_r <= cend_r;
      end
    end
  end

  // result registers
  logic          dv_r, df_r, rw_r, strobe_r;
  logic [OW-1:0] ds_r;
  logic [LW-1:0] dl_r;
  logic [7:0]    rd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= cmd.emit_plain || cmd.clr_start || cmd.rd_done || cmd.wfin;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_plain || cmd.clr_start || cmd.rd_done || cmd.wfin) begin
      dv_r <= 1'b0;
      ds_r <= '0;
      dl_r <= '0;
      df_r <= 1'b0;
      rd_r <= '0;
      rw_r <= 1'b0;
      if (cmd.rd_done) begin
        rd_r <= wmap_q ? byte_q : 8'd0;
        rw_r <= wmap_q;
      end
      if (cmd.wfin && (cend_r > deliv_r)) begin
        dv_r <= 1'b1;
        ds_r <= deliv_r[OW-1:0];
        dl_r <= cend_r - deliv_r;
        df_r <= (deliv_r == '0);
      end
    end
  end

  assign out_valid              = strobe_r;
  assign out_delivery_valid     = dv_r;
  assign out_delivery_start     = ds_r;
  assign out_delivery_len       = dl_r;
  assign out_first_delivery     = df_r;
  assign out_out_of_order_count = ooo_r;
  assign out_repeat_count       = rtx_r;
  assign out_conflict_count     = cfl_r;
  assign out_conflict_seen      = (cfl_r != '0);
  assign out_read_data          = rd_r;
  assign out_read_written       = rw_r;

endmodule

FILE: rtl/tcp_stream_reassembly_overlap_check.sv
// top level of the tcp stream reassembly block with overlap check
// One request is taken at a rising edge with start high and busy low: a segment
// byte, a read of a stored byte, or a clear of the flow. Each request gives one
// result on the out_ ports, valid for the single cycle that out_valid is high;
// the receiver cannot stall, so results are never held.
// A segment byte or a read goes through decode with buffer read, update and the
// result register; a segment item that stores no byte and does not close a segment,
// or an undefined request, goes from decode straight to the result register.
// A closing byte also walks the hole list: setup, a read and a process step per
// hole entry, a split step when a hole is split, and a finish step; a closing item
// without a byte skips the byte update. The list holds up to 128 entries, read one
// at a time through the single hole bank port.
// A clear and the reset both run a sweep over the 16384 entries of the written map,
// one entry a cycle, during which busy stays high; the result of a clear comes out
// in the first cycle of that sweep.
// Apart from a clear, a new request may be given in the cycle its predecessor's
// result is shown. overlap_policy sits at APB address 0 and keeps its value over
// a clear; it is reset to 0 (first byte wins).
module tcp_stream_reassembly_overlap_check (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic [1:0]                 in_req_type,
  input  logic [31:0]                in_seg_seq,
  input  logic [7:0]                 in_data_byte,
  input  logic                       in_first_byte,
  input  logic                       in_last_byte,
  input  logic                       in_no_payload,
  input  logic [tsr_pkg::OFF_W-1:0]  in_read_offset,
  output logic                       out_valid,
  output logic                       out_delivery_valid,
  output logic [tsr_pkg::OFF_W-1:0]  out_delivery_start,
  output logic [tsr_pkg::LEN_W-1:0]  out_delivery_len,
  output logic                       out_first_delivery,
  output logic [31:0]                out_out_of_order_count,
  output logic [31:0]                out_repeat_count,
  output logic [31:0]                out_conflict_count,
  output logic                       out_conflict_seen,
  output logic [7:0]                 out_read_data,
  output logic                       out_read_written,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [2:0]                 paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  tsr_pkg::cmd_t    cmd;
  tsr_pkg::status_t st;
  logic             policy_r;

  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'd0 : {31'd0, policy_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r <= 1'b0;
    end else if (psel && penable && pwrite && !paddr[2]) begin
      policy_r <= pwdata[0];
    end
  end

  tsr_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .st    (st),
    .cmd   (cmd)
  );

  tsr_dp u_dp (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cmd                    (cmd),
    .st                     (st),
    .policy                 (policy_r),
    .in_req_type            (in_req_type),
    .in_seg_seq             (in_seg_seq),
    .in_data_byte           (in_data_byte),
    .in_first_byte          (in_first_byte),
    .in_last_byte           (in_last_byte),
    .in_no_payload          (in_no_payload),
    .in_read_offset         (in_read_offset),
    .out_valid              (out_valid),
    .out_delivery_valid     (out_delivery_valid),
    .out_delivery_start     (out_delivery_start),
    .out_delivery_len       (out_delivery_len),
    .out_first_delivery     (out_first_delivery),
    .out_out_of_order_count (out_out_of_order_count),
    .out_repeat_count       (out_repeat_count),
    .out_conflict_count     (out_conflict_count),
    .out_conflict_seen      (out_conflict_seen),
    .out_read_data          (out_read_data),
    .out_read_written       (out_read_written)
  );

endmodule
